FILE: rtl/core/mrf_pkg.sv
package mrf_pkg;

  localparam int MAX_WORDS_DEF = 123;
  localparam int WL_W = 7;
  localparam int QDEPTH = 2;

  localparam logic [2:0] KIND_RD_HOLD  = 3'd0;
  localparam logic [2:0] KIND_RD_INPUT = 3'd1;
  localparam logic [2:0] KIND_WR_SINGLE = 3'd2;
  localparam logic [2:0] KIND_WR_MULTI = 3'd3;
  localparam logic [2:0] KIND_DATA     = 3'd4;

  localparam logic [7:0] FC_RD_HOLD   = 8'h03;
  localparam logic [7:0] FC_RD_INPUT  = 8'h04;
  localparam logic [7:0] FC_WR_SINGLE = 8'h06;
  localparam logic [7:0] FC_WR_MULTI  = 8'h10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    OP_ERR      = 3'd0,
    OP_REQ      = 3'd1,
    OP_HDR      = 3'd2,
    OP_WORD     = 3'd3,
    OP_WORD_END = 3'd4
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  slave;
    logic [7:0]  code;
    logic [15:0] addr;
    logic [15:0] val;
  } cmd_t;

  function automatic logic [7:0] func_code(input logic [2:0] kind);
    logic [7:0] c;
    case (kind)
      KIND_RD_HOLD:   c = FC_RD_HOLD;
      KIND_RD_INPUT:  c = FC_RD_INPUT;
      KIND_WR_SINGLE: c = FC_WR_SINGLE;
      default:        c = FC_WR_MULTI;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/mrf_front.sv
module mrf_front #(
  parameter int MAX_WORDS = mrf_pkg::MAX_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [7:0]         in_slave_address,
  input  logic [15:0]        in_register_address,
  input  logic [15:0]        in_count_or_value,
  input  logic [15:0]        in_data_word,
  input  logic               q_full,
  output logic               q_push,
  output mrf_pkg::cmd_t      q_cmd
);

  logic [mrf_pkg::WL_W-1:0] words_left_r, words_left_nxt;
  logic                     bad;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    bad = 1'b1;
    case (in_kind) inside
      [mrf_pkg::KIND_RD_HOLD:mrf_pkg::KIND_WR_MULTI]: bad = (words_left_r != '0);
      mrf_pkg::KIND_DATA: bad = (words_left_r == '0);
      default: bad = 1'b1;
    endcase
    if (!bad && in_kind == mrf_pkg::KIND_WR_MULTI &&
        (in_count_or_value == 16'd0 || in_count_or_value > 16'(MAX_WORDS))) begin
      bad = 1'b1;
    end
  end

  always_comb begin
    q_cmd.slave    = in_slave_address;
    q_cmd.code     = mrf_pkg::func_code(in_kind);
    q_cmd.addr     = in_register_address;
    q_cmd.val      = in_count_or_value;
    q_cmd.op       = mrf_pkg::OP_REQ;
    words_left_nxt = words_left_r;
    if (bad) begin
      q_cmd.op = mrf_pkg::OP_ERR;
    end else if (in_kind == mrf_pkg::KIND_DATA) begin
      q_cmd.val      = in_data_word;
      q_cmd.op       = (words_left_r == mrf_pkg::WL_W'(1)) ? mrf_pkg::OP_WORD_END
                                                            : mrf_pkg::OP_WORD;
      words_left_nxt = words_left_r - mrf_pkg::WL_W'(1);
    end else if (in_kind == mrf_pkg::KIND_WR_MULTI) begin
      q_cmd.op       = mrf_pkg::OP_HDR;
      words_left_nxt = in_count_or_value[mrf_pkg::WL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_left_r <= '0;
    end else if (q_push) begin
      words_left_r <= words_left_nxt;
    end
  end

endmodule

FILE: rtl/core/mrf_queue.sv
module mrf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mrf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mrf_pkg::cmd_t head_cmd
);

  localparam int PW = $clog2(mrf_pkg::QDEPTH);

  mrf_pkg::cmd_t entry_r [mrf_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == (PW+1)'(mrf_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/mrf_back.sv
module mrf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  mrf_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_frame_end,
  output logic          out_last,
  output logic          out_error
);

  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt, crc_base;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_frame_end_r, out_last_r, out_error_r;
  logic        adv, emit;
  logic [7:0]  sel_byte;
  logic        is_crc, is_crc_hi, is_last, is_err;

  assign adv  = !out_valid_r || !out_stall;
  assign emit = adv && head_valid;
  assign pop  = emit && is_last;

  always_comb begin
    sel_byte  = 8'h00;
    is_crc    = 1'b0;
    is_crc_hi = 1'b0;
    is_last   = 1'b0;
    is_err    = 1'b0;
    case (head_cmd.op)
      mrf_pkg::OP_REQ, mrf_pkg::OP_HDR: begin
        case (idx_r)
          3'd0: sel_byte = head_cmd.slave;
          3'd1: sel_byte = head_cmd.code;
          3'd2: sel_byte = head_cmd.addr[15:8];
          3'd3: sel_byte = head_cmd.addr[7:0];
          3'd4: sel_byte = head_cmd.val[15:8];
          3'd5: sel_byte = head_cmd.val[7:0];
          3'd6: begin
            if (head_cmd.op == mrf_pkg::OP_HDR) begin
              sel_byte = {head_cmd.val[6:0], 1'b0};
              is_last  = 1'b1;
            end else begin
              sel_byte = crc_r[7:0];
              is_crc   = 1'b1;
            end
          end
          default: begin
            sel_byte  = crc_r[15:8];
            is_crc    = 1'b1;
            is_crc_hi = 1'b1;
            is_last   = 1'b1;
          end
        endcase
      end
      mrf_pkg::OP_WORD, mrf_pkg::OP_WORD_END: begin
        case (idx_r)
          3'd0: sel_byte = head_cmd.val[15:8];
          3'd1: begin
            sel_byte = head_cmd.val[7:0];
            is_last  = (head_cmd.op == mrf_pkg::OP_WORD);
          end
          3'd2: begin
            sel_byte = crc_r[7:0];
            is_crc   = 1'b1;
          end
          default: begin
            sel_byte  = crc_r[15:8];
            is_crc    = 1'b1;
            is_crc_hi = 1'b1;
            is_last   = 1'b1;
          end
        endcase
      end
      default: begin
        is_err  = 1'b1;
        is_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    crc_base = crc_r;
    if (idx_r == 3'd0 &&
        (head_cmd.op == mrf_pkg::OP_REQ || head_cmd.op == mrf_pkg::OP_HDR)) begin
      crc_base = mrf_pkg::CRC_INIT;
    end
    crc_nxt = crc_r;
    idx_nxt = idx_r;
    if (emit) begin
      idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;
      if (is_crc_hi) begin
        crc_nxt = mrf_pkg::CRC_INIT;
      end else if (!is_crc && !is_err) begin
        crc_nxt = mrf_pkg::crc16_feed(crc_base, sel_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= mrf_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      if (adv) begin
        out_valid_r <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r      <= sel_byte;
      out_frame_end_r <= is_crc_hi;
      out_last_r      <= is_last;
      out_error_r     <= is_err;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_frame_end_r;
  assign out_last      = out_last_r;
  assign out_error     = out_error_r;

endmodule

FILE: rtl/core/modbus_rtu_request_framer_top.sv
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/stall   | kind, slave, register address, count/value, data word
// out     | output    | out_valid/stall  | out_byte, frame_end, last, error
//
// One beat leaves per clock while the output does not stall: a read or write-single item is
// 8 bytes long, a write-multiple header 7, a data word 2, or 4 with the CRC; a rejected item is one error beat.
// The byte emitter in the back end sets that rate; the front end classifies and queues
// up to two items, the one being emitted included.
// Reset is synchronous and active low; it empties the queue and clears the open frame.
// A stall on the output holds the registered beat; the input stalls only when the queue is full.
module modbus_rtu_request_framer_top #(
  parameter int MAX_WORDS = mrf_pkg::MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_slave_address,
  input  logic [15:0] in_register_address,
  input  logic [15:0] in_count_or_value,
  input  logic [15:0] in_data_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_frame_end,
  output logic        out_last,
  output logic        out_error
);

  mrf_pkg::cmd_t push_cmd, head_cmd;
  logic          q_full, q_push, q_pop, head_valid;

  mrf_front #(.MAX_WORDS(MAX_WORDS)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_slave_address    (in_slave_address),
    .in_register_address (in_register_address),
    .in_count_or_value   (in_count_or_value),
    .in_data_word        (in_data_word),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_cmd               (push_cmd)
  );

  mrf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  mrf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_last      (out_last),
    .out_error     (out_error)
  );

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && !out_frame_end && out_byte == 8'h00)
    else $error("error beat is not a lone zero beat");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_last)
    else $error("frame end without last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule
